@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the text cell buffer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge once out of reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that must never be seen once out of reset.
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

@@ hdl/tcb_pkg.sv @@
// ----------------------------------------------------------------------------
// tcb_pkg
// Shared constants and controller/datapath interface types for the text
// cell buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcb_pkg;

   localparam int COLS   = 80;
   localparam int ROWS   = 25;
   localparam int CELLS  = COLS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   // widest index: row 255, column 255
   localparam int IDX_W  = $clog2(255 * COLS + 256);
   localparam int CPOS_W = 11;
   localparam int CELL_W = 16;

   localparam logic [7:0] CH_ESC      = 8'h1B;
   localparam logic [7:0] CH_BS       = 8'h08;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;

   localparam logic REQ_PUT  = 1'b0;
   localparam logic REQ_READ = 1'b1;

   typedef struct packed {
      logic clear_step;   // zero one cell of the store
      logic capture;      // latch the incoming word
      logic execute;      // perform the latched request, load output register
   } cmd_type;

   typedef struct packed {
      logic clear_last;   // clearing pass is at its last cell
      logic out_free;     // output register empty or being drained
   } status_type;

endpackage

`default_nettype wire

@@ hdl/tcb_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcb_ctrl
// Sequencer: clearing pass after reset, then capture / execute per word.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tcb_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire tcb_pkg::status_type status,
   output tcb_pkg::cmd_type        cmd
);
   import tcb_pkg::*;

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC} state_type;

   state_type state_ff;
   logic      req_tready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         req_tready_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               if (status.clear_last) begin
                  state_ff      <= ST_IDLE;
                  req_tready_ff <= 1'b1;
               end
            end
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff      <= ST_EXEC;
                  req_tready_ff <= 1'b0;
               end
            end
            ST_EXEC: begin
               if (status.out_free) begin
                  state_ff      <= ST_IDLE;
                  req_tready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff      <= ST_CLEAR;
               req_tready_ff <= 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      cmd.clear_step = (state_ff == ST_CLEAR);
      cmd.capture    = req_tvalid && req_tready_ff;
      cmd.execute    = (state_ff == ST_EXEC) && status.out_free;
   end

   assign req_tready = req_tready_ff;

   `ASSERT_CLK(a_ready_only_idle, req_tready_ff |-> (state_ff == ST_IDLE), "ready outside idle")
   `ASSERT_CLK(a_exec_returns, cmd.execute |=> (state_ff == ST_IDLE && req_tready_ff), "exec did not return to idle")

endmodule

`default_nettype wire

@@ hdl/tcb_datapath.sv @@
// ----------------------------------------------------------------------------
// tcb_datapath
// Request latch, cell index, escape filter, cell store and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tcb_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire tcb_pkg::cmd_type    cmd,
   output tcb_pkg::status_type      status,
   input  wire logic                req_type,
   input  wire logic [7:0]          ch,
   input  wire logic [7:0]          col_x,
   input  wire logic [7:0]          row_y,
   input  wire logic [7:0]          attr_color,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [31:0]              rsp_tdata,  // [15:0] read_data, [26:16] cursor_pos
   output logic                     rsp_tuser   // [0] cursor_valid
);
   import tcb_pkg::*;

   typedef enum logic [1:0] {PH_TEXT, PH_ESC, PH_NUM1, PH_NUM2} phase_type;

   // latched request
   logic       req_type_ff;
   logic [7:0] ch_ff, col_ff, row_ff, color_ff;

   phase_type  phase_ff, phase_in;
   logic [ADDR_W-1:0] clr_addr_ff;

   logic [CELL_W-1:0] mem [CELLS];

   // output register
   logic              rsp_valid_ff;
   logic [CELL_W-1:0] rd_ff;
   logic              hit_ff;
   logic              cvalid_ff;
   logic [CPOS_W-1:0] cpos_ff;

   logic [IDX_W-1:0]  idx;
   logic              in_range, col_ok, is_put, is_digit, wr_en, cvalid_in;
   logic [7:0]        glyph;
   logic [IDX_W-1:0]  cpos_full;

   always_comb begin
      idx       = IDX_W'(row_ff) * IDX_W'(COLS) + IDX_W'(col_ff);
      in_range  = idx < IDX_W'(CELLS);
      col_ok    = col_ff < 8'(COLS);
      is_put    = (req_type_ff == REQ_PUT);
      is_digit  = (ch_ff >= CH_ZERO) && (ch_ff <= CH_NINE);
      glyph     = (ch_ff == CH_BS) ? CH_SPACE : ch_ff;
      wr_en     = is_put && (ch_ff != CH_ESC) && (phase_ff == PH_TEXT) && in_range;
      cvalid_in = wr_en && col_ok;
      cpos_full = (ch_ff == CH_BS) ? idx : idx + IDX_W'(1);
   end

   // escape filter
   always_comb begin
      phase_in = phase_ff;
      if (ch_ff == CH_ESC) begin
         phase_in = PH_ESC;
      end else begin
         case (phase_ff)
            PH_TEXT: phase_in = PH_TEXT;
            PH_ESC:  phase_in = (ch_ff == CH_LBRACKET) ? PH_NUM1 : PH_TEXT;
            PH_NUM1: begin
               if (!is_digit) begin
                  phase_in = (ch_ff == CH_SEMI) ? PH_NUM2 : PH_TEXT;
               end
            end
            PH_NUM2: begin
               if (!is_digit) begin
                  phase_in = PH_TEXT;
               end
            end
            default: phase_in = PH_TEXT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_type_ff <= req_type;
         ch_ff       <= ch;
         col_ff      <= col_x;
         row_ff      <= row_y;
         color_ff    <= attr_color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_TEXT;
         clr_addr_ff <= '0;
      end else begin
         if (cmd.execute && is_put) begin
            phase_ff <= phase_in;
         end
         if (cmd.clear_step) begin
            clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         end
      end
   end

   // cell store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         mem[clr_addr_ff] <= '0;
      end else if (cmd.execute && wr_en) begin
         mem[idx[ADDR_W-1:0]] <= {color_ff, glyph};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rd_ff <= mem[idx[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.execute) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         hit_ff    <= (req_type_ff == REQ_READ) && in_range;
         cvalid_ff <= cvalid_in;
         cpos_ff   <= cvalid_in ? cpos_full[CPOS_W-1:0] : '0;
      end
   end

   always_comb begin
      status.clear_last = (clr_addr_ff == ADDR_W'(CELLS - 1));
      status.out_free   = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(32 - CPOS_W - CELL_W)'(0), cpos_ff, hit_ff ? rd_ff : CELL_W'(0)};
   assign rsp_tuser  = cvalid_ff;

   `ASSERT_CLK(a_valid_from_exec, $rose(rsp_valid_ff) |-> $past(cmd.execute), "result without execute")
   `ASSERT_NEVER(a_clear_vs_work, cmd.clear_step && (cmd.execute || cmd.capture), "work during clear")

endmodule

`default_nettype wire

@@ hdl/text_cell_buffer_with_escape_filter_core.sv @@
// ----------------------------------------------------------------------------
// text_cell_buffer_with_escape_filter_core
// Text-mode cell store (80 x 25 cells of colour:char) with an ESC [ n ; n x
// filter on the put path.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel req_*: one word per put or read. tuser selects put (0)
//    or read (1); tdata carries char, column, row and colour.
//  - Response channel rsp_*: exactly one word per request. tdata carries the
//    read cell (zero for puts and out-of-range reads) and the new cursor
//    index; tuser flags a cursor move.
//  - Reset: a clearing pass zeroes the 2000 cells, one per cycle; req_tready
//    stays low until the pass is done.
//  - Timing: a request is taken and then executed once the output register
//    is free; req_tready stays low until then, so no new word is taken
//    before the last is executed. The response is registered at execution.
//    The cell store is accessed for a word only in its execute cycle.
//  - Back-pressure: the response sits in an output register. A new request
//    is still accepted while it waits; execution of that request holds
//    until the register is drained.
// ----------------------------------------------------------------------------
`default_nettype none

module text_cell_buffer_with_escape_filter_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // request
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // [7:0] ch, [15:8] col_x, [23:16] row_y,
                                        // [31:24] attr_color
   input  wire logic        req_tuser,  // [0] req_type
   // response
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,  // [15:0] read_data, [26:16] cursor_pos,
                                        // [31:27] zero
   output logic             rsp_tuser   // [0] cursor_valid
);
   import tcb_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: clearing pass, capture, execute
   tcb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // cell store, escape filter and output register
   tcb_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_type   (req_tuser),
      .ch         (req_tdata[7:0]),
      .col_x      (req_tdata[15:8]),
      .row_y      (req_tdata[23:16]),
      .attr_color (req_tdata[31:24]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

@@ test/tb_text_cell_buffer_with_escape_filter_core.sv @@
// ----------------------------------------------------------------------------
// tb_text_cell_buffer_with_escape_filter_core
// Self-checking bench for the text cell buffer. A shadow of the screen and
// of the escape filter predicts every response word. Traffic is a directed
// opening followed by random text, reads and CSI runs. Both channels idle
// at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import tcb_pkg::*;

typedef enum logic [1:0] {
   ESC_IDLE,
   ESC_OPENED,
   ESC_FIRST_ARG,
   ESC_SECOND_ARG
} esc_state_type;

typedef struct packed {
   logic [CELL_W-1:0] read_data;
   logic              cursor_valid;
   logic [CPOS_W-1:0] cursor_pos;
} cell_reply_type;

class cell_scoreboard;
   logic [CELL_W-1:0] screen [CELLS];
   esc_state_type     esc_state;
   cell_reply_type    pending_replies [$];
   int                mismatches;

   function new();
      foreach (screen[i]) screen[i] = '0;
      esc_state  = ESC_IDLE;
      mismatches = 0;
   endfunction

   function bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   // shadow update and predicted response for one accepted request word
   function void note_request(logic kind, logic [7:0] c, logic [7:0] x,
                              logic [7:0] y, logic [7:0] colour);
      int unsigned idx;
      cell_reply_type r;
      idx = y * COLS + x;
      r   = '0;
      if (kind == REQ_READ) begin
         if (idx < CELLS) r.read_data = screen[idx];
      end else if (c == CH_ESC) begin
         esc_state = ESC_OPENED;   // ESC restarts the filter from any state
      end else begin
         case (esc_state)
            ESC_IDLE: begin
               if (idx < CELLS) begin
                  screen[idx] = {colour, (c == CH_BS) ? CH_SPACE : c};
                  if (x < COLS) begin
                     r.cursor_valid = 1'b1;
                     r.cursor_pos   = CPOS_W'((c == CH_BS) ? idx : idx + 1);
                  end
               end
            end
            ESC_OPENED: begin
               esc_state = (c == CH_LBRACKET) ? ESC_FIRST_ARG : ESC_IDLE;
            end
            ESC_FIRST_ARG: begin
               if (!is_digit(c)) esc_state = (c == CH_SEMI) ? ESC_SECOND_ARG : ESC_IDLE;
            end
            default: begin
               if (!is_digit(c)) esc_state = ESC_IDLE;
            end
         endcase
      end
      pending_replies.push_back(r);
   endfunction

   function void check_reply(logic [CELL_W-1:0] rd, logic cv, logic [CPOS_W-1:0] cp);
      cell_reply_type want;
      if (pending_replies.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected response: read_data=%h cursor_valid=%b cursor_pos=%0d",
                     rd, cv, cp);
         return;
      end
      want = pending_replies.pop_front();
      if (rd !== want.read_data || cv !== want.cursor_valid || cp !== want.cursor_pos) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: read_data %h/%h cursor_valid %b/%b cursor_pos %0d/%0d",
                     want.read_data, rd, want.cursor_valid, cv, want.cursor_pos, cp);
      end
   endfunction
endclass

module tb_text_cell_buffer_with_escape_filter_core;

   localparam int LIMIT        = 200000;  // room for the clearing pass and every word, many times over
   localparam int RANDOM_WORDS = 1750;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [7:0] ch, [15:8] col_x, [23:16] row_y, [31:24] attr_color
   logic        req_tuser  = 1'b0; // [0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [15:0] read_data, [26:16] cursor_pos
   logic        rsp_tuser;         // [0] cursor_valid

   cell_scoreboard model = new();
   bit             no_idle = 1'b0;  // stretches of back-to-back traffic on both sides
   int             words_sent = 0;
   int             cycle_count = 0;

   always #1 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   text_cell_buffer_with_escape_filter_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   function automatic int draw_idle();
      return no_idle ? 0 : $urandom_range(0, 4);
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] rand_col();
      return 8'($urandom_range(0, COLS - 1));
   endfunction

   function automatic logic [7:0] rand_row();
      return 8'($urandom_range(0, ROWS - 1));
   endfunction

   function automatic logic [7:0] rand_digit();
      return CH_ZERO + 8'($urandom_range(0, 9));
   endfunction

   // Offers one request word and returns at the edge that takes it.
   // tvalid is only dropped when a gap is drawn, so back-to-back words
   // never see a low/high pair in one step.
   task automatic send_word(input logic kind, input logic [7:0] c, input logic [7:0] x,
                            input logic [7:0] y, input logic [7:0] colour);
      int gap;
      gap = draw_idle();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {colour, y, x, c};
      do @(posedge clock); while (!req_tready);
      model.note_request(kind, c, x, y, colour);
      words_sent++;
   endtask

   task automatic put(input logic [7:0] c, input logic [7:0] x, input logic [7:0] y,
                      input logic [7:0] colour);
      send_word(REQ_PUT, c, x, y, colour);
   endtask

   // char and colour of a read are don't-care, so they carry noise
   task automatic peek(input logic [7:0] x, input logic [7:0] y);
      send_word(REQ_READ, rand_byte(), x, y, rand_byte());
   endtask

   // ESC [ digits ; digits terminator, or a broken variant of it
   task automatic escape_run(input bit broken);
      logic [7:0] t;
      put(CH_ESC, rand_byte(), rand_byte(), rand_byte());
      if (broken && $urandom_range(0, 1)) begin
         // something other than '[' after ESC falls back to text
         do t = rand_byte(); while (t == CH_LBRACKET || t == CH_ESC);
         put(t, rand_byte(), rand_byte(), rand_byte());
      end else begin
         put(CH_LBRACKET, rand_byte(), rand_byte(), rand_byte());
         repeat ($urandom_range(0, 3)) put(rand_digit(), rand_byte(), rand_byte(), rand_byte());
         if ($urandom_range(0, 3) != 0) begin
            put(CH_SEMI, rand_byte(), rand_byte(), rand_byte());
            repeat ($urandom_range(0, 3))
               put(rand_digit(), rand_byte(), rand_byte(), rand_byte());
         end
         // reads inside a run are served and leave the filter alone
         if ($urandom_range(0, 7) == 0) peek(rand_col(), rand_row());
         if (broken) begin
            put(CH_ESC, rand_byte(), rand_byte(), rand_byte());   // restart mid-run
         end else begin
            do t = rand_byte();
            while (model.is_digit(t) || t == CH_ESC || t == CH_SEMI);
            put(t, rand_byte(), rand_byte(), rand_byte());
         end
      end
   endtask

   // response side: random stalls, every taken word is checked
   initial begin : reply_sink
      int stall;
      wait (reset == 1'b0);
      forever begin
         stall = draw_idle();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         model.check_reply(rsp_tdata[CELL_W-1:0], rsp_tuser, rsp_tdata[CELL_W +: CPOS_W]);
      end
   end

   initial begin : watchdog
      wait (cycle_count >= LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      int         base;
      logic [7:0] x;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // req_tready stays low through the clearing pass; send_word just waits

      // --- directed opening ---
      peek(8'd0, 8'd0);                          // cleared store reads zero
      put(8'h41, 8'd0, 8'd0, 8'h07);             // 'A' top left, cursor to 1
      put(8'hFF, 8'(COLS - 1), 8'(ROWS - 1), 8'hFF); // last cell, cursor one past the end
      peek(8'(COLS - 1), 8'(ROWS - 1));
      put(8'h00, 8'hFF, 8'hFF, 8'hAA);           // far off screen: dropped
      peek(8'hFF, 8'hFF);                        // off screen read gives zero
      put(8'h5A, 8'd100, 8'd3, 8'h3C);           // column past the edge: lands in row 4, no cursor
      peek(8'd20, 8'd4);
      put(CH_BS, 8'd5, 8'd1, 8'h1F);             // backspace blanks the cell, cursor stays put
      peek(8'd5, 8'd1);
      // full CSI run with a read in the middle
      put(CH_ESC, 8'd0, 8'd0, 8'h00);
      peek(8'd0, 8'd0);
      put(CH_LBRACKET, 8'd0, 8'd0, 8'h00);
      put(CH_ZERO, 8'd0, 8'd0, 8'h00);
      put(CH_NINE, 8'd0, 8'd0, 8'h00);
      put(CH_SEMI, 8'd0, 8'd0, 8'h00);
      put(CH_ZERO + 8'd5, 8'd0, 8'd0, 8'h00);
      put(8'h6D, 8'd0, 8'd0, 8'h00);             // 'm' closes the run
      put(8'h42, 8'd0, 8'd0, 8'h70);             // plain text again
      put(CH_ESC, 8'd2, 8'd0, 8'h00);
      put(8'h78, 8'd2, 8'd0, 8'h00);             // ESC then not '[': swallowed, back to text
      put(CH_ESC, 8'd3, 8'd0, 8'h00);
      put(CH_LBRACKET, 8'd3, 8'd0, 8'h00);
      put(CH_ESC, 8'd3, 8'd0, 8'h00);            // ESC inside the first number restarts
      put(CH_LBRACKET, 8'd3, 8'd0, 8'h00);
      put(CH_SEMI, 8'd3, 8'd0, 8'h00);
      put(CH_SEMI, 8'd3, 8'd0, 8'h00);           // second ';' ends the run
      put(8'h43, 8'd1, 8'd0, 8'h2E);
      peek(8'd1, 8'd0);

      // --- random traffic ---
      base = words_sent;
      while (words_sent - base < RANDOM_WORDS) begin
         if ($urandom_range(0, 31) == 0) no_idle = ($urandom_range(0, 2) == 0);
         case ($urandom_range(0, 9))
            0, 1, 2: put(rand_byte(), rand_col(), rand_row(), rand_byte());
            3:       put(CH_BS, rand_col(), rand_row(), rand_byte());
            4, 5:    peek(rand_col(), rand_row());
            6:       escape_run(1'b0);
            7:       escape_run(1'b1);
            8:       send_word(logic'($urandom_range(0, 1)), rand_byte(), rand_byte(),
                               rand_byte(), rand_byte());
            default: begin
               // column beyond the row but index still on screen
               x = 8'($urandom_range(COLS, 255));
               put(rand_byte(), x, 8'($urandom_range(0, (CELLS - 1 - x) / COLS)), rand_byte());
            end
         endcase
      end
      req_tvalid <= 1'b0;

      while (model.pending_replies.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);   // catch any stray word after the last one
      if (model.mismatches == 0 && model.pending_replies.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/tcb_pkg.sv
hdl/tcb_ctrl.sv
hdl/tcb_datapath.sv
hdl/text_cell_buffer_with_escape_filter_core.sv
test/tb_text_cell_buffer_with_escape_filter_core.sv
